// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/crev_pkg.sv =====
package crev_pkg;

   localparam int NUM_BUTTONS    = 48;
   localparam int SHIFT_POSITION = 25;
   localparam int NUM_PADS       = 16;

   localparam int BTN_W    = 48;
   localparam int PAD_IDX_W = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

   // Scan positions: buttons first, then encoder, then the two strips.
   localparam int PEND_W = BTN_W + 3;
   localparam int POS_W  = 6;
   localparam logic [POS_W-1:0] POS_ENC     = POS_W'(BTN_W);
   localparam logic [POS_W-1:0] POS_STRIP_L = POS_W'(BTN_W + 1);
   localparam logic [POS_W-1:0] POS_STRIP_R = POS_W'(BTN_W + 2);

   localparam int SHIFT_BIT = SHIFT_POSITION % BTN_W;
   localparam logic [BTN_W-1:0] BTN_MASK =
      BTN_W'((65'd1 << NUM_BUTTONS) - 65'd1);
   localparam logic [BTN_W-1:0] SHIFT_ONEHOT = BTN_W'(1) << SHIFT_BIT;

   localparam logic [1:0] KIND_BUTTON  = 2'd0;
   localparam logic [1:0] KIND_ENCODER = 2'd1;
   localparam logic [1:0] KIND_STRIP   = 2'd2;
   localparam logic [1:0] KIND_PAD     = 2'd3;

   // Strip scaling: v * 51 / 40 = ((v * 51) >> 3) / 5, the /5 done by a
   // reciprocal multiply that is exact for every 19-bit dividend.
   localparam int MUL_W = 19;
   localparam logic [MUL_W-1:0] STRIP_GAIN = MUL_W'(51);
   localparam logic [MUL_W-1:0] RECIP_5    = MUL_W'(419431);
   localparam int RECIP_SHIFT = 21;

   localparam logic [11:0] PAD_THRESHOLD_RESET = 12'd200;

endpackage

// ===== hdl/controller_report_event_decoder.sv =====
// Control-surface report decoder. A control report (req_mode 0) is scanned
// one position per cycle: 48 button positions, then the encoder, then the
// left and right strips. The scan stops after the highest position that
// changed. After a control report is taken, req_ready stays low while the
// scan visits each position up to the highest pending one, while each strip
// event makes two passes through the shared 19x19 multiplier (times 51 in
// ST_MUL, then the reciprocal of 5 in ST_DIV), and in the closing scan step.
// A report with no change only runs the closing scan step, and a pad report
// (req_mode 1) passes through ST_PAD, where a pad event waits for a free
// output word. The scan holds while an emitted word waits with rsp_ready low.
// req_ready is high only between reports; csr writes are taken at any time.
`include "assert_macros.svh"

module controller_report_event_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [47:0] req_button_bits,
   input  logic [3:0]  req_encoder_position,
   input  logic [15:0] req_strip_left,
   input  logic [15:0] req_strip_right,
   input  logic [7:0]  req_pad_number,
   input  logic [11:0] req_pad_pressure,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_kind,
   output logic [5:0]  rsp_event_index,
   output logic [16:0] rsp_event_value,
   output logic        rsp_shift_held,
   output logic        rsp_last_event,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_pad_threshold
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SCAN = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;

   localparam int PW = crev_pkg::PEND_W;
   localparam int MW = crev_pkg::MUL_W;

   logic [2:0]                  state_ff, state_in;
   logic [crev_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [PW-1:0]               pend_ff, pend_in;
   logic [11:0]                 thr_ff, thr_in;
   logic [crev_pkg::BTN_W-1:0]  btn_store_ff, btn_store_in;
   logic [3:0]                  enc_last_ff, enc_last_in;
   logic [15:0]                 strip_l_last_ff, strip_l_last_in;
   logic [15:0]                 strip_r_last_ff, strip_r_last_in;
   logic [crev_pkg::NUM_PADS-1:0] pad_active_ff, pad_active_in;

   // Held report payload
   logic [crev_pkg::BTN_W-1:0]  bits_ff, bits_in;
   logic                        enc_up_ff, enc_up_in;
   logic [15:0]                 strip_l_ff, strip_l_in;
   logic [15:0]                 strip_r_ff, strip_r_in;
   logic                        pad_hit_ff, pad_hit_in;
   logic [5:0]                  pad_idx_ff, pad_idx_in;
   logic [16:0]                 pad_val_ff, pad_val_in;

   logic [2*MW-1:0]             prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [5:0]  index_ff, index_in;
   logic [16:0] value_ff, value_in;
   logic        shift_ff, shift_in;
   logic        last_ff, last_in;

   logic                        accept;
   logic                        out_free;
   logic                        emit;
   logic [PW-1:0]               pend_clr;
   logic [MW-1:0]               mul_a, mul_b;
   logic [crev_pkg::BTN_W-1:0]  upd_mask;
   logic [crev_pkg::BTN_W-1:0]  diff;
   logic                        enc_chg, strip_l_chg, strip_r_chg;
   logic                        pad_in_range;
   logic [crev_pkg::PAD_IDX_W-1:0] pad_sel;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pend_clr  = pend_ff & ~(PW'(1) << pos_ff);

   assign upd_mask = crev_pkg::BTN_MASK | crev_pkg::SHIFT_ONEHOT;
   assign diff = (req_button_bits ^ btn_store_ff) & crev_pkg::BTN_MASK
                 & ~crev_pkg::SHIFT_ONEHOT;
   assign enc_chg     = (req_encoder_position != enc_last_ff);
   assign strip_l_chg = (req_strip_left != 16'd0) && (req_strip_left != strip_l_last_ff);
   assign strip_r_chg = (req_strip_right != 16'd0) && (req_strip_right != strip_r_last_ff);
   assign pad_in_range = (req_pad_number < 8'(crev_pkg::NUM_PADS));
   assign pad_sel = req_pad_number[crev_pkg::PAD_IDX_W-1:0];

   // Shared multiplier: strip times gain, then reduced product times 1/5.
   always_comb begin
      if (state_ff == ST_DIV) begin
         mul_a = prod_ff[MW+2:3];
         mul_b = crev_pkg::RECIP_5;
      end else begin
         mul_a = (pos_ff == crev_pkg::POS_STRIP_R) ? MW'(strip_r_ff) : MW'(strip_l_ff);
         mul_b = crev_pkg::STRIP_GAIN;
      end
   end

   always_comb begin
      state_in        = state_ff;
      pos_in          = pos_ff;
      pend_in         = pend_ff;
      thr_in          = thr_ff;
      btn_store_in    = btn_store_ff;
      enc_last_in     = enc_last_ff;
      strip_l_last_in = strip_l_last_ff;
      strip_r_last_in = strip_r_last_ff;
      pad_active_in   = pad_active_ff;
      bits_in         = bits_ff;
      enc_up_in       = enc_up_ff;
      strip_l_in      = strip_l_ff;
      strip_r_in      = strip_r_ff;
      pad_hit_in      = pad_hit_ff;
      pad_idx_in      = pad_idx_ff;
      pad_val_in      = pad_val_ff;
      prod_in         = prod_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      kind_in         = kind_ff;
      index_in        = index_ff;
      value_in        = value_ff;
      shift_in        = shift_ff;
      last_in         = last_ff;
      emit            = 1'b0;

      if (csr_valid && csr_ready) begin
         thr_in = csr_pad_threshold;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pos_in = '0;
               if (!req_mode) begin
                  bits_in      = req_button_bits;
                  strip_l_in   = req_strip_left;
                  strip_r_in   = req_strip_right;
                  btn_store_in = (btn_store_ff & ~upd_mask) | (req_button_bits & upd_mask);
                  enc_up_in = ((enc_last_ff < req_encoder_position) ||
                               (enc_last_ff == 4'hF && req_encoder_position == 4'h0)) &&
                              !(enc_last_ff == 4'h0 && req_encoder_position == 4'hF);
                  enc_last_in = req_encoder_position;
                  if (strip_l_chg) begin
                     strip_l_last_in = req_strip_left;
                  end
                  if (strip_r_chg) begin
                     strip_r_last_in = req_strip_right;
                  end
                  pend_in  = {strip_r_chg, strip_l_chg, enc_chg, diff};
                  state_in = ST_SCAN;
               end else begin
                  pad_idx_in = 6'(req_pad_number);
                  pad_hit_in = 1'b0;
                  pad_val_in = '0;
                  if (pad_in_range) begin
                     if (req_pad_pressure > thr_ff) begin
                        pad_active_in[pad_sel] = 1'b1;
                        pad_hit_in = 1'b1;
                        pad_val_in = 17'(req_pad_pressure >> 4);
                     end else if (pad_active_ff[pad_sel]) begin
                        pad_active_in[pad_sel] = 1'b0;
                        pad_hit_in = 1'b1;
                     end
                  end
                  state_in = ST_PAD;
               end
            end
         end
         ST_SCAN: begin
            if (pend_ff == '0) begin
               state_in = ST_IDLE;
            end else if (!pend_ff[pos_ff]) begin
               pos_in = pos_ff + 1'b1;
            end else if (pos_ff == crev_pkg::POS_STRIP_L || pos_ff == crev_pkg::POS_STRIP_R) begin
               state_in = ST_MUL;
            end else if (out_free) begin
               emit = 1'b1;
               if (pos_ff == crev_pkg::POS_ENC) begin
                  kind_in  = crev_pkg::KIND_ENCODER;
                  index_in = '0;
                  value_in = 17'(enc_up_ff);
               end else begin
                  kind_in  = crev_pkg::KIND_BUTTON;
                  index_in = pos_ff;
                  value_in = 17'(bits_ff[pos_ff]);
               end
            end
         end
         ST_MUL: begin
            prod_in  = mul_a * mul_b;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Hold the quotient multiply until the output word is free.
            if (out_free) begin
               prod_in  = mul_a * mul_b;
               emit     = 1'b1;
               kind_in  = crev_pkg::KIND_STRIP;
               index_in = (pos_ff == crev_pkg::POS_STRIP_R) ? 6'd1 : 6'd0;
               value_in = prod_in[crev_pkg::RECIP_SHIFT +: 17];
               state_in = ST_SCAN;
            end
         end
         ST_PAD: begin
            if (!pad_hit_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in  = crev_pkg::KIND_PAD;
               index_in = pad_idx_ff;
               value_in = pad_val_ff;
               shift_in = btn_store_ff[crev_pkg::SHIFT_BIT];
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
         shift_in     = btn_store_ff[crev_pkg::SHIFT_BIT];
         last_in      = (pend_clr == '0);
         pend_in      = pend_clr;
         pos_in       = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         pos_ff          <= '0;
         pend_ff         <= '0;
         thr_ff          <= crev_pkg::PAD_THRESHOLD_RESET;
         btn_store_ff    <= '0;
         enc_last_ff     <= '0;
         strip_l_last_ff <= '0;
         strip_r_last_ff <= '0;
         pad_active_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         pos_ff          <= pos_in;
         pend_ff         <= pend_in;
         thr_ff          <= thr_in;
         btn_store_ff    <= btn_store_in;
         enc_last_ff     <= enc_last_in;
         strip_l_last_ff <= strip_l_last_in;
         strip_r_last_ff <= strip_r_last_in;
         pad_active_ff   <= pad_active_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff    <= bits_in;
      enc_up_ff  <= enc_up_in;
      strip_l_ff <= strip_l_in;
      strip_r_ff <= strip_r_in;
      pad_hit_ff <= pad_hit_in;
      pad_idx_ff <= pad_idx_in;
      pad_val_ff <= pad_val_in;
      prod_ff    <= prod_in;
      kind_ff    <= kind_in;
      index_ff   <= index_in;
      value_ff   <= value_in;
      shift_ff   <= shift_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_kind  = kind_ff;
   assign rsp_event_index = index_ff;
   assign rsp_event_value = value_ff;
   assign rsp_shift_held  = shift_ff;
   assign rsp_last_event  = last_ff;

   `ASSERT_IMPLY(a_scan_pos, clock, reset, state_ff == ST_SCAN && pend_ff != '0, pos_ff <= crev_pkg::POS_STRIP_R, "scan ran past last position")
   `ASSERT_IMPLY(a_mul_strip, clock, reset, state_ff == ST_MUL || state_ff == ST_DIV, (pos_ff == crev_pkg::POS_STRIP_L || pos_ff == crev_pkg::POS_STRIP_R) && pend_ff[pos_ff], "multiplier used off a pending strip")
   `ASSERT_NEXT(a_last_drains, clock, reset, emit && last_in, pend_ff == '0, "last word sent with events pending")
   `ASSERT_IMPLY(a_pend_busy, clock, reset, pend_ff != '0, state_ff != ST_IDLE, "idle with events pending")

endmodule

// ===== tb/tb_controller_report_event_decoder.sv =====
`timescale 1ns / 1ps

module tb_controller_report_event_decoder;

   localparam logic MODE_CONTROL = 1'b0;
   localparam logic MODE_PAD     = 1'b1;
   localparam int   SETTLE_CYCLES = 64;
   localparam int   HOLD_CYCLES   = 300;
   localparam int   TIMEOUT_NS    = 5_000_000;
   localparam int   MAX_REPORTED  = 10;

   typedef struct {
      logic        mode;
      logic [47:0] buttons;
      logic [3:0]  encoder;
      logic [15:0] strip_l;
      logic [15:0] strip_r;
      logic [7:0]  pad;
      logic [11:0] pressure;
   } report_type;

   typedef struct {
      logic [1:0]  kind;
      logic [5:0]  index;
      logic [16:0] value;
      logic        shift;
      logic        last;
   } ctl_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_mode = 1'b0;
   logic [47:0] req_button_bits = '0;
   logic [3:0]  req_encoder_position = '0;
   logic [15:0] req_strip_left = '0;
   logic [15:0] req_strip_right = '0;
   logic [7:0]  req_pad_number = '0;
   logic [11:0] req_pad_pressure = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_event_kind;
   logic [5:0]  rsp_event_index;
   logic [16:0] rsp_event_value;
   logic        rsp_shift_held;
   logic        rsp_last_event;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [11:0] csr_pad_threshold = '0;

   // predicted block state
   logic [47:0] held_buttons;
   logic [3:0]  enc_last;
   logic [15:0] strip_last [2];
   logic        pad_active [crev_pkg::NUM_PADS];
   logic [11:0] pad_limit;

   ctl_event_type pending_events [$];

   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   logic rsp_hold = 1'b0;
   event hold_go;

   int mismatch_count = 0;
   int stray_count = 0;
   int events_checked = 0;
   int control_sent = 0;
   int pad_sent = 0;
   int thresholds_written = 0;

   controller_report_event_decoder dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_mode             (req_mode),
      .req_button_bits      (req_button_bits),
      .req_encoder_position (req_encoder_position),
      .req_strip_left       (req_strip_left),
      .req_strip_right      (req_strip_right),
      .req_pad_number       (req_pad_number),
      .req_pad_pressure     (req_pad_pressure),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_event_index      (rsp_event_index),
      .rsp_event_value      (rsp_event_value),
      .rsp_shift_held       (rsp_shift_held),
      .rsp_last_event       (rsp_last_event),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_pad_threshold    (csr_pad_threshold)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver stall, counted here so the sender keeps pushing meanwhile
   always begin
      @(hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   function automatic void push_event(logic [1:0] kind, logic [5:0] index,
                                      logic [16:0] value, logic shift);
      ctl_event_type e;
      e.kind  = kind;
      e.index = index;
      e.value = value;
      e.shift = shift;
      e.last  = 1'b0;
      pending_events.push_back(e);
   endfunction

   function automatic void reset_prediction();
      held_buttons = '0;
      enc_last     = '0;
      strip_last[0] = '0;
      strip_last[1] = '0;
      for (int p = 0; p < crev_pkg::NUM_PADS; p++) pad_active[p] = 1'b0;
      pad_limit = crev_pkg::PAD_THRESHOLD_RESET;
   endfunction

   function automatic void predict_events(report_type r);
      int unsigned first;
      logic        shift;
      logic        up;
      logic [15:0] strip_now [2];
      first = pending_events.size();
      if (r.mode == MODE_PAD) begin
         shift = held_buttons[crev_pkg::SHIFT_BIT];
         if (r.pad < crev_pkg::NUM_PADS) begin
            if (r.pressure > pad_limit) begin
               pad_active[r.pad] = 1'b1;
               push_event(crev_pkg::KIND_PAD, r.pad[5:0], 17'(r.pressure >> 4), shift);
            end else if (pad_active[r.pad]) begin
               pad_active[r.pad] = 1'b0;
               push_event(crev_pkg::KIND_PAD, r.pad[5:0], 17'd0, shift);
            end
         end
      end else begin
         // shift is latched before the scan so every event sees the new state
         held_buttons[crev_pkg::SHIFT_BIT] = r.buttons[crev_pkg::SHIFT_BIT];
         shift = held_buttons[crev_pkg::SHIFT_BIT];
         for (int i = 0; i < crev_pkg::NUM_BUTTONS; i++) begin
            if (i != crev_pkg::SHIFT_BIT && r.buttons[i] != held_buttons[i]) begin
               held_buttons[i] = r.buttons[i];
               push_event(crev_pkg::KIND_BUTTON, 6'(i), 17'(r.buttons[i]), shift);
            end
         end
         if (r.encoder != enc_last) begin
            up = ((enc_last < r.encoder) || (enc_last == 4'hF && r.encoder == 4'h0)) &&
                 !(enc_last == 4'h0 && r.encoder == 4'hF);
            enc_last = r.encoder;
            push_event(crev_pkg::KIND_ENCODER, 6'd0, 17'(up), shift);
         end
         strip_now[0] = r.strip_l;
         strip_now[1] = r.strip_r;
         for (int k = 0; k < 2; k++) begin
            if (strip_now[k] != 16'd0 && strip_now[k] != strip_last[k]) begin
               strip_last[k] = strip_now[k];
               push_event(crev_pkg::KIND_STRIP, 6'(k),
                          17'((32'(strip_now[k]) * 32'd51) / 32'd40), shift);
            end
         end
      end
      if (pending_events.size() > first) pending_events[$].last = 1'b1;
   endfunction

   function automatic report_type control_report(logic [47:0] bits, logic [3:0] enc,
                                                 logic [15:0] sl, logic [15:0] sr);
      report_type r;
      r.mode     = MODE_CONTROL;
      r.buttons  = bits;
      r.encoder  = enc;
      r.strip_l  = sl;
      r.strip_r  = sr;
      r.pad      = 8'($urandom());
      r.pressure = 12'($urandom());
      return r;
   endfunction

   function automatic report_type pad_report(logic [7:0] num, logic [11:0] press);
      report_type r;
      r.mode     = MODE_PAD;
      r.buttons  = 48'({$urandom(), $urandom()});
      r.encoder  = 4'($urandom());
      r.strip_l  = 16'($urandom());
      r.strip_r  = 16'($urandom());
      r.pad      = num;
      r.pressure = press;
      return r;
   endfunction

   // mostly small edits of the current state so scans stay short and varied
   function automatic report_type random_report();
      int          pick;
      int          flips;
      int          near;
      logic [47:0] bits;
      logic [3:0]  enc;
      logic [15:0] strips [2];
      logic [7:0]  num;
      logic [11:0] press;
      if ($urandom_range(99) < 60) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            bits = 48'({$urandom(), $urandom()});
         end else begin
            bits = held_buttons;
            if (pick >= 25) begin
               flips = $urandom_range(1, 4);
               repeat (flips) bits[$urandom_range(47)] ^= 1'b1;
            end
         end
         case ($urandom_range(3))
            0: enc = enc_last;
            1: enc = enc_last + 4'd1;
            2: enc = enc_last - 4'd1;
            default: enc = 4'($urandom());
         endcase
         for (int k = 0; k < 2; k++) begin
            pick = $urandom_range(99);
            if (pick < 30) strips[k] = 16'd0;
            else if (pick < 50) strips[k] = strip_last[k];
            else strips[k] = 16'($urandom());
         end
         return control_report(bits, enc, strips[0], strips[1]);
      end
      num = ($urandom_range(99) < 85) ? 8'($urandom_range(crev_pkg::NUM_PADS - 1))
                                       : 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 40) begin
         near = int'(pad_limit) + $urandom_range(4) - 2;
         if (near < 0) near = 0;
         if (near > 4095) near = 4095;
         press = 12'(near);
      end else if (pick < 55) begin
         press = 12'd0;
      end else begin
         press = 12'($urandom());
      end
      return pad_report(num, press);
   endfunction

   task automatic send_report(report_type r);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid            <= 1'b1;
      req_mode             <= r.mode;
      req_button_bits      <= r.buttons;
      req_encoder_position <= r.encoder;
      req_strip_left       <= r.strip_l;
      req_strip_right      <= r.strip_r;
      req_pad_number       <= r.pad;
      req_pad_pressure     <= r.pressure;
      do @(posedge clock); while (!req_ready);
      predict_events(r);
      if (r.mode == MODE_PAD) pad_sent++;
      else control_sent++;
   endtask

   // drop valid, drain the expected words, then let any silent report finish
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(logic [11:0] value);
      csr_valid         <= 1'b1;
      csr_pad_threshold <= value;
      do @(posedge clock); while (!csr_ready);
      pad_limit = value;
      thresholds_written++;
      csr_valid <= 1'b0;
   endtask

   task automatic test_control_extremes();
      send_report(control_report({48{1'b1}}, 4'hF, 16'hFFFF, 16'hFFFF));
      send_report(control_report(48'd0, 4'h0, 16'hFFFF, 16'd0));
      send_report(control_report(crev_pkg::SHIFT_ONEHOT, 4'h0, 16'd0, 16'd0));
      send_report(control_report(crev_pkg::SHIFT_ONEHOT | 48'd1 | (48'd1 << 47), 4'h1,
                                 16'd1, 16'd40));
      send_report(control_report(48'd1 << 47, 4'h0, 16'd1, 16'd40));
      send_report(control_report(48'd1 << 47, 4'h7, 16'd2, 16'd0));
      send_report(control_report(48'd1 << 47, 4'h3, 16'd2, 16'd0));
   endtask

   task automatic test_pad_reports();
      send_report(pad_report(8'd0, 12'hFFF));
      send_report(pad_report(8'd0, 12'hFFF));
      send_report(pad_report(8'd0, 12'd0));
      send_report(pad_report(8'd0, 12'd0));
      send_report(pad_report(8'd15, 12'd201));
      send_report(pad_report(8'd15, 12'd200));
      send_report(pad_report(8'(crev_pkg::NUM_PADS), 12'hFFF));
      send_report(pad_report(8'hFF, 12'hFFF));
      send_report(pad_report(8'd3, 12'd200));
      // shift seen on a pad word, then released on a button word
      send_report(control_report(crev_pkg::SHIFT_ONEHOT | (48'd1 << 47), 4'h3,
                                 16'd0, 16'd0));
      send_report(pad_report(8'd7, 12'd300));
      send_report(control_report(48'd0, 4'h3, 16'd0, 16'd0));
   endtask

   task automatic test_threshold_extremes();
      wait_for_idle();
      write_threshold(12'd0);
      send_report(pad_report(8'd5, 12'd1));
      send_report(pad_report(8'd5, 12'd0));
      send_report(pad_report(8'd5, 12'd1));
      wait_for_idle();
      write_threshold(12'hFFF);
      send_report(pad_report(8'd5, 12'hFFF));
      send_report(pad_report(8'd6, 12'hFFF));
   endtask

   task automatic test_random_traffic(int count, int tx_pct, int rx_pct,
                                      logic [11:0] threshold);
      wait_for_idle();
      write_threshold(threshold);
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (count) send_report(random_report());
   endtask

   task automatic test_output_backpressure();
      wait_for_idle();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      -> hold_go;
      repeat (12) begin
         send_report(control_report(48'({$urandom(), $urandom()}), 4'($urandom()),
                                    16'($urandom()), 16'($urandom())));
      end
   endtask

   always @(posedge clock) begin : check_events
      ctl_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= MAX_REPORTED)
               $display("unexpected word: kind %0d index %0d value %0d shift %0d last %0d",
                        rsp_event_kind, rsp_event_index, rsp_event_value,
                        rsp_shift_held, rsp_last_event);
         end else begin
            want = pending_events.pop_front();
            events_checked++;
            if (rsp_event_kind !== want.kind || rsp_event_index !== want.index ||
                rsp_event_value !== want.value || rsp_shift_held !== want.shift ||
                rsp_last_event !== want.last) begin
               mismatch_count++;
               if (mismatch_count + stray_count <= MAX_REPORTED)
                  $display({"word %0d mismatch: expected kind %0d index %0d value %0d ",
                            "shift %0d last %0d, got kind %0d index %0d value %0d ",
                            "shift %0d last %0d"},
                           events_checked, want.kind, want.index, want.value,
                           want.shift, want.last, rsp_event_kind, rsp_event_index,
                           rsp_event_value, rsp_shift_held, rsp_last_event);
            end
         end
      end
   end

   initial begin
      reset_prediction();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_control_extremes();
      test_pad_reports();
      test_threshold_extremes();
      test_random_traffic(48, 12, 45, 12'($urandom_range(1, 4094)));
      test_random_traffic(48, 45, 12, 12'($urandom_range(1, 4094)));
      test_random_traffic(48, 0, 0, crev_pkg::PAD_THRESHOLD_RESET);
      test_output_backpressure();
      wait_for_idle();
      $display("sent %0d control and %0d pad reports over %0d threshold settings",
               control_sent, pad_sent, thresholds_written);
      $display("checked %0d event words, %0d mismatched, %0d unexpected, %0d missing",
               events_checked, mismatch_count, stray_count, pending_events.size());
      if (mismatch_count == 0 && stray_count == 0 && pending_events.size() == 0) begin
         $display("** controller_report_event_decoder: PASSED **");
      end else begin
         $display("** controller_report_event_decoder: FAILED **");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout with %0d event words outstanding", pending_events.size());
      $display("** controller_report_event_decoder: FAILED **");
      $finish;
   end

endmodule
